### hdl/length_prefixed_deframer_assert.svh
// Assertion macros for the deframer.
// Define NO_ASSERTIONS to compile them out.
`ifndef LENGTH_PREFIXED_DEFRAMER_ASSERT_SVH
`define LENGTH_PREFIXED_DEFRAMER_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define LPD_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("deframer assertion failed");

`define LPD_ASSERT_MSG(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

`else

`define LPD_ASSERT(label, clk, rst_n, prop)

`define LPD_ASSERT_MSG(label, clk, rst_n, prop, msg)

`endif

`endif

### hdl/lpd_pkg.sv
package lpd_pkg;

    localparam logic [31:0] MAX_SIZE_RESET = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_BODY   = 2'd1,
        PH_ERROR  = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        KIND_BODY       = 2'd0,
        KIND_EMPTY      = 2'd1,
        KIND_SIZE_ERROR = 2'd2
    } kind_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } item_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  body_byte;
        logic        first;
        logic        last;
        logic [31:0] length;
    } result_t;

endpackage

### hdl/lpd_in_reg.sv
module lpd_in_reg (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  logic [7:0]     stream_byte,
    input  logic           advance,
    output lpd_pkg::item_t item
);

    logic       valid_reg;
    logic [7:0] data_reg;

    // Take a new item whenever the held one is empty or moves on this cycle.
    assign in_stall = valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            data_reg <= stream_byte;
        end
    end

    assign item.valid = valid_reg;
    assign item.data  = data_reg;

endmodule

### hdl/lpd_parse.sv
`include "length_prefixed_deframer_assert.svh"

module lpd_parse (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_write,
    input  logic [31:0]      cfg_data,
    input  lpd_pkg::item_t   item,
    input  logic             advance,
    output logic             res_valid,
    output lpd_pkg::result_t res
);

    lpd_pkg::phase_t phase_reg, phase_next;
    logic [1:0]      header_count_reg, header_count_next;
    logic [31:0]     header_shift_reg, header_shift_next;
    logic [31:0]     body_remaining_reg, body_remaining_next;
    logic [31:0]     current_length_reg, current_length_next;
    logic [31:0]     max_size_reg;
    logic [31:0]     shifted;
    logic [31:0]     remaining_dec;
    logic            step;

    assign step          = item.valid && advance;
    assign shifted       = {header_shift_reg[23:0], item.data};
    assign remaining_dec = (body_remaining_reg != 32'd0) ? body_remaining_reg - 32'd1 : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_size_reg <= lpd_pkg::MAX_SIZE_RESET;
        end
        else if (cfg_write)
        begin
            max_size_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= lpd_pkg::PH_HEADER;
            header_count_reg   <= 2'd0;
            header_shift_reg   <= 32'd0;
            body_remaining_reg <= 32'd0;
            current_length_reg <= 32'd0;
        end
        else
        begin
            phase_reg          <= phase_next;
            header_count_reg   <= header_count_next;
            header_shift_reg   <= header_shift_next;
            body_remaining_reg <= body_remaining_next;
            current_length_reg <= current_length_next;
        end
    end

    always_comb
    begin
        phase_next          = phase_reg;
        header_count_next   = header_count_reg;
        header_shift_next   = header_shift_reg;
        body_remaining_next = body_remaining_reg;
        current_length_next = current_length_reg;
        res_valid           = 1'b0;
        res.kind            = lpd_pkg::KIND_BODY;
        res.body_byte       = 8'd0;
        res.first           = 1'b0;
        res.last            = 1'b0;
        res.length          = current_length_reg;

        if (step)
        begin
            unique case (phase_reg)
                lpd_pkg::PH_HEADER:
                begin
                    if (header_count_reg != 2'd3)
                    begin
                        header_shift_next = shifted;
                        header_count_next = header_count_reg + 2'd1;
                    end
                    else
                    begin
                        header_count_next   = 2'd0;
                        header_shift_next   = 32'd0;
                        current_length_next = shifted;
                        res.length          = shifted;
                        if (shifted > max_size_reg)
                        begin
                            phase_next = lpd_pkg::PH_ERROR;
                            res_valid  = 1'b1;
                            res.kind   = lpd_pkg::KIND_SIZE_ERROR;
                        end
                        else if (shifted == 32'd0)
                        begin
                            res_valid = 1'b1;
                            res.kind  = lpd_pkg::KIND_EMPTY;
                            res.last  = 1'b1;
                        end
                        else
                        begin
                            body_remaining_next = shifted;
                            phase_next          = lpd_pkg::PH_BODY;
                        end
                    end
                end
                lpd_pkg::PH_BODY:
                begin
                    res_valid           = 1'b1;
                    res.kind            = lpd_pkg::KIND_BODY;
                    res.body_byte       = item.data;
                    res.first           = (body_remaining_reg == current_length_reg);
                    res.last            = (body_remaining_reg <= 32'd1);
                    body_remaining_next = remaining_dec;
                    if (remaining_dec == 32'd0)
                    begin
                        phase_next = lpd_pkg::PH_HEADER;
                    end
                end
                default:
                begin
                    // error phase: drop every byte until reset
                end
            endcase
        end
    end

    `LPD_ASSERT(a_error_silent, clk, rst_n, (phase_reg == lpd_pkg::PH_ERROR) |-> !res_valid)
    `LPD_ASSERT(a_count_in_header, clk, rst_n,
        (header_count_reg != 2'd0) |-> (phase_reg == lpd_pkg::PH_HEADER))
    `LPD_ASSERT(a_body_remaining, clk, rst_n,
        (phase_reg == lpd_pkg::PH_BODY) |->
        (body_remaining_reg != 32'd0 && body_remaining_reg <= current_length_reg))
    `LPD_ASSERT_MSG(a_error_sticks, clk, rst_n,
        (phase_reg == lpd_pkg::PH_ERROR) |=> (phase_reg == lpd_pkg::PH_ERROR),
        "deframer left the error phase without reset")
    `LPD_ASSERT(a_result_needs_item, clk, rst_n, res_valid |-> step)

endmodule

### hdl/lpd_out_reg.sv
module lpd_out_reg (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             res_valid,
    input  lpd_pkg::result_t res,
    input  logic             out_stall,
    output logic             advance,
    output logic             out_valid,
    output lpd_pkg::result_t out_res
);

    logic             valid_reg;
    lpd_pkg::result_t res_reg;

    // Move on when the result register is empty or being drained.
    assign advance = !valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

### hdl/length_prefixed_deframer.sv
// Length-prefixed deframer: splits a byte stream into messages, each a 4-byte
// big-endian length followed by that many body bytes. One byte is accepted per
// cycle while the consumer does not stall; a byte's result (if any) goes out
// through the input register and the result register: the first holds the byte
// while the parse logic works on it, and the second captures the outcome once it
// is empty or being drained. Header bytes give no item out; a complete header
// gives an empty-message item for length zero, or a size-error item when the
// length exceeds max_message_size, after which the block drops every byte until
// reset. Write max_message_size only while the block is idle; all ones means
// unlimited and is the reset value. No clearing pass is needed after reset.
module length_prefixed_deframer (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] max_message_size,
    // input byte channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  stream_byte,
    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  result_kind,
    output logic [7:0]  body_byte,
    output logic        first_of_message,
    output logic        last_of_message,
    output logic [31:0] message_length
);

    lpd_pkg::item_t   item;
    lpd_pkg::result_t res;
    lpd_pkg::result_t out_res;
    logic             res_valid;
    logic             advance;

    // The register is always writable.
    assign cfg_ready = 1'b1;

    // Hold the accepted byte until the parse stage can take it.
    lpd_in_reg u_in_reg (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .stream_byte (stream_byte),
        .advance     (advance),
        .item        (item)
    );

    // Header collection, length check and body marking.
    lpd_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_data  (max_message_size),
        .item      (item),
        .advance   (advance),
        .res_valid (res_valid),
        .res       (res)
    );

    // Result register: decouples the parser from a stalled consumer.
    lpd_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .out_stall (out_stall),
        .advance   (advance),
        .out_valid (out_valid),
        .out_res   (out_res)
    );

    assign result_kind      = out_res.kind;
    assign body_byte        = out_res.body_byte;
    assign first_of_message = out_res.first;
    assign last_of_message  = out_res.last;
    assign message_length   = out_res.length;

endmodule
